[hw/rtl/sebs_pkg.sv]
// Package with the field widths, action codes and divider constants of the sparse extent store.
package sebs_pkg;

    localparam int LBA_W   = 12;
    localparam int WORD_W  = 7;
    localparam int DATA_W  = 32;
    localparam int FILL_W  = 8;
    localparam int ACT_W   = 2;
    localparam int CFG_W   = 4;

    localparam int WORD_SPAN = 1 << WORD_W;
    localparam int LBA_SPAN  = 1 << LBA_W;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic [ACT_W-1:0] ACT_READ   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FORMAT = 2'd2;

    localparam int RECIP_W = LBA_W + 1;

    // Floor of 2^LBA_W divided by the extent size, indexed by the extent size.
    localparam logic [RECIP_W-1:0] RECIP [1 << CFG_W] = '{
        RECIP_W'(0),
        RECIP_W'(LBA_SPAN / 1),  RECIP_W'(LBA_SPAN / 2),  RECIP_W'(LBA_SPAN / 3),
        RECIP_W'(LBA_SPAN / 4),  RECIP_W'(LBA_SPAN / 5),  RECIP_W'(LBA_SPAN / 6),
        RECIP_W'(LBA_SPAN / 7),  RECIP_W'(LBA_SPAN / 8),  RECIP_W'(LBA_SPAN / 9),
        RECIP_W'(LBA_SPAN / 10), RECIP_W'(LBA_SPAN / 11), RECIP_W'(LBA_SPAN / 12),
        RECIP_W'(LBA_SPAN / 13), RECIP_W'(LBA_SPAN / 14), RECIP_W'(LBA_SPAN / 15)
    };

endpackage

[hw/rtl/sparse_extent_block_store.sv]
// Top level of the sparse extent block store: a thin-provisioned RAM disk with word access.
//
//  Channel   Direction  Signals                         Contents
//  --------  ---------  ------------------------------  --------------------------------------
//  request   in         s_tvalid s_tready s_tdata       lba, word_index, write_data, fill_value
//                       s_tuser                         action
//  response  out        m_tvalid m_tready m_tdata       read_data, status
//  config    in         i_cfg_we i_cfg_wdata            extent_sectors
//
// One request at a time. From transfer to a loaded output register a mapped read or write
// passes division, map read, store access and hand-over, an unmapped read or a rejected
// write skips the store access, and an unused action or a sector beyond the disk goes from
// division to hand-over; a first write zeroes its slot first, and a format sweeps the map.
// After reset the same sweep runs before s_tready first rises; config writes are always taken.
// A response waits in the output register, so a stalled m_tready blocks only the next hand-over.
module sparse_extent_block_store
    import sebs_pkg::*;
#(
    parameter int SECTOR_COUNT       = 4096,
    parameter int SECTOR_WORDS       = 128,
    parameter int MAX_EXTENT_SECTORS = 8,
    parameter int POOL_EXTENTS       = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // lba [11:0], word_index [18:12], write_data [50:19], fill_value [58:51], zero [63:59]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action [1:0]
    input  logic [ACT_W-1:0]     s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_data [31:0], status [32], zero [39:33]
    output logic [M_TDATA_W-1:0] m_tdata,

    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    // Derived sizes of the map, the pool and the store.
    localparam int SLOT_WORDS  = MAX_EXTENT_SECTORS * SECTOR_WORDS;
    localparam int STORE_WORDS = POOL_EXTENTS * SLOT_WORDS;
    localparam int MAP_AW      = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
    localparam int SLOT_W      = (POOL_EXTENTS > 1) ? $clog2(POOL_EXTENTS) : 1;
    localparam int SU_W        = $clog2(POOL_EXTENTS + 1);
    localparam int WITHIN_W    = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
    localparam int ST_AW       = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int SWEEP_MAX   = (SECTOR_COUNT > SLOT_WORDS) ? SECTOR_COUNT : SLOT_WORDS;
    localparam int CNT_W       = (SWEEP_MAX > 1) ? $clog2(SWEEP_MAX) : 1;
    localparam int MAP_DW      = SLOT_W + 1;
    localparam int ES_CAP      = (MAX_EXTENT_SECTORS < SECTOR_COUNT) ?
                                 MAX_EXTENT_SECTORS : SECTOR_COUNT;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_MAP   = 8'b0000_1000,
        S_ZERO  = 8'b0001_0000,
        S_WR    = 8'b0010_0000,
        S_RD    = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // Memories: the extent map (valid bit over slot number) and the word store.
    logic [MAP_DW-1:0] mem_map   [SECTOR_COUNT];
    logic [DATA_W-1:0] mem_store [STORE_WORDS];

    // Control registers.
    t_state            r_state,      n_state;
    logic [CNT_W-1:0]  r_cnt,        n_cnt;
    logic              r_clr_res,    n_clr_res;
    logic [SU_W-1:0]   r_slots,      n_slots;
    logic [FILL_W-1:0] r_fill,       n_fill;
    logic [CFG_W-1:0]  r_cfg,        n_cfg;
    logic              r_out_valid,  n_out_valid;

    // Payload registers.
    logic [ACT_W-1:0]    r_act;
    logic [LBA_W-1:0]    r_lba;
    logic [WORD_W-1:0]   r_word;
    logic [DATA_W-1:0]   r_wdata;
    logic [FILL_W-1:0]   r_fillv;
    logic [LBA_W-1:0]    r_q0;
    logic [MAP_AW-1:0]   r_ext;
    logic [WITHIN_W-1:0] r_within;
    logic [SLOT_W-1:0]   r_slot,       n_slot;
    logic [DATA_W-1:0]   r_res_data,   n_res_data;
    logic                r_res_status, n_res_status;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_out_status;
    logic [MAP_DW-1:0]   r_map_rd;
    logic [DATA_W-1:0]   r_st_rd;

    // Combinational signals.
    logic                    accept;
    logic                    out_free;
    logic [CFG_W-1:0]        es;
    logic [2*LBA_W:0]        q_prod;
    logic [LBA_W+CFG_W-1:0]  qe;
    logic [LBA_W-1:0]        diff;
    logic [CFG_W:0]          rem0;
    logic                    rem_ge;
    logic [LBA_W-1:0]        ext_c;
    logic [CFG_W-1:0]        rem_c;
    logic [WITHIN_W-1:0]     within_c;
    logic                    in_range;
    logic [DATA_W-1:0]       pattern;
    logic [WORD_W-1:0]       word_tab [WORD_SPAN];
    logic                    map_valid;
    logic [SLOT_W-1:0]       map_slot;
    logic                    map_we;
    logic                    map_re;
    logic [MAP_AW-1:0]       map_addr;
    logic [MAP_DW-1:0]       map_wdata;
    logic                    st_we;
    logic                    st_re;
    logic [SLOT_W-1:0]       st_slot;
    logic [WITHIN_W-1:0]     st_off;
    logic [ST_AW-1:0]        st_addr;
    logic [DATA_W-1:0]       st_wdata;

    // Word positions beyond the sector wrap round; the table is built from constants.
    for (genvar g = 0; g < WORD_SPAN; g++) begin : g_word_tab
        assign word_tab[g] = WORD_W'(g % SECTOR_WORDS);
    end

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (r_state == S_IDLE);
    assign out_free = !r_out_valid || m_tready;
    assign pattern  = {4{r_fill}};

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {(M_TDATA_W - DATA_W - 1)'(0), r_out_status, r_out_data};

    // The active extent size: zero counts as one, and it never exceeds the slot size.
    always_comb begin
        es = r_cfg;
        if (es == '0) begin
            es = CFG_W'(1);
        end
        if (32'(es) > ES_CAP) begin
            es = CFG_W'(ES_CAP);
        end
    end

    // Extent number by reciprocal multiplication. The first estimate taken on transfer is
    // the true quotient or one below it, and the remainder check in S_DIV corrects it.
    assign q_prod   = (2*LBA_W+1)'(s_tdata[LBA_W-1:0]) * (2*LBA_W+1)'(RECIP[es]);
    assign qe       = (LBA_W+CFG_W)'(r_q0) * (LBA_W+CFG_W)'(es);
    assign diff     = r_lba - qe[LBA_W-1:0];
    assign rem0     = diff[CFG_W:0];
    assign rem_ge   = (rem0 >= {1'b0, es});
    assign ext_c    = rem_ge ? r_q0 + LBA_W'(1) : r_q0;
    assign rem_c    = rem_ge ? CFG_W'(rem0 - {1'b0, es}) : rem0[CFG_W-1:0];
    assign within_c = WITHIN_W'(32'(rem_c) * SECTOR_WORDS) + WITHIN_W'(r_word);
    assign in_range = (32'(r_lba) < SECTOR_COUNT);

    assign map_valid = r_map_rd[SLOT_W];
    assign map_slot  = r_map_rd[SLOT_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_clr_res    = r_clr_res;
        n_slots      = r_slots;
        n_fill       = r_fill;
        n_cfg        = i_cfg_we ? i_cfg_wdata : r_cfg;
        n_out_valid  = r_out_valid && !m_tready;
        n_slot       = r_slot;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;

        map_we    = 1'b0;
        map_re    = 1'b0;
        map_addr  = MAP_AW'(ext_c);
        map_wdata = '0;
        st_we     = 1'b0;
        st_re     = 1'b0;
        st_slot   = r_slot;
        st_off    = r_within;
        st_wdata  = r_wdata;

        case (r_state)
            S_CLEAR: begin
                // Sweep the map one entry a cycle, leaving every extent unmapped.
                map_we   = 1'b1;
                map_addr = r_cnt[MAP_AW-1:0];
                if (r_cnt == CNT_W'(SECTOR_COUNT - 1)) begin
                    n_cnt     = '0;
                    n_clr_res = 1'b0;
                    n_state   = r_clr_res ? S_DONE : S_IDLE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_res_data   = '0;
                n_res_status = 1'b0;
                if (r_act == ACT_FORMAT) begin
                    n_slots   = '0;
                    n_fill    = r_fillv;
                    n_cnt     = '0;
                    n_clr_res = 1'b1;
                    n_state   = S_CLEAR;
                end else if ((r_act == ACT_READ || r_act == ACT_WRITE) && in_range) begin
                    map_re  = 1'b1;
                    n_state = S_MAP;
                end else begin
                    // Unused action, or a sector beyond the disk.
                    if (r_act == ACT_READ) begin
                        n_res_data = pattern;
                    end
                    n_state = S_DONE;
                end
            end
            S_MAP: begin
                if (r_act == ACT_READ) begin
                    if (map_valid) begin
                        st_re   = 1'b1;
                        st_slot = map_slot;
                        n_state = S_RD;
                    end else begin
                        n_res_data = pattern;
                        n_state    = S_DONE;
                    end
                end else if (map_valid) begin
                    n_slot  = map_slot;
                    n_state = S_WR;
                end else if (32'(r_slots) >= POOL_EXTENTS) begin
                    n_res_status = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    // First write to this extent: hand out the next slot and zero it.
                    map_we    = 1'b1;
                    map_addr  = r_ext;
                    map_wdata = {1'b1, SLOT_W'(r_slots)};
                    n_slot    = SLOT_W'(r_slots);
                    n_slots   = r_slots + SU_W'(1);
                    n_cnt     = '0;
                    n_state   = S_ZERO;
                end
            end
            S_ZERO: begin
                st_we    = 1'b1;
                st_off   = r_cnt[WITHIN_W-1:0];
                st_wdata = '0;
                if (r_cnt == CNT_W'(SLOT_WORDS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_WR;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_WR: begin
                st_we   = 1'b1;
                n_state = S_DONE;
            end
            S_RD: begin
                n_res_data = r_st_rd;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign st_addr = ST_AW'(st_slot) * ST_AW'(SLOT_WORDS) + ST_AW'(st_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr_res   <= 1'b0;
            r_slots     <= '0;
            r_fill      <= '0;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_clr_res   <= n_clr_res;
            r_slots     <= n_slots;
            r_fill      <= n_fill;
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act   <= s_tuser;
            r_lba   <= s_tdata[LBA_W-1:0];
            r_word  <= word_tab[s_tdata[LBA_W +: WORD_W]];
            r_wdata <= s_tdata[LBA_W+WORD_W +: DATA_W];
            r_fillv <= s_tdata[LBA_W+WORD_W+DATA_W +: FILL_W];
            r_q0    <= q_prod[2*LBA_W-1:LBA_W];
        end
        if (r_state == S_DIV) begin
            r_ext    <= MAP_AW'(ext_c);
            r_within <= within_c;
        end
        r_slot       <= n_slot;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        if (r_state == S_DONE && out_free) begin
            r_out_data   <= r_res_data;
            r_out_status <= r_res_status;
        end
    end

    // Extent map: one port, read data registered.
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_addr] <= map_wdata;
        end
        if (map_re) begin
            r_map_rd <= mem_map[map_addr];
        end
    end

    // Word store: one port, read data registered.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            mem_store[st_addr] <= st_wdata;
        end
        if (st_re) begin
            r_st_rd <= mem_store[st_addr];
        end
    end

endmodule

[sim/sparse_extent_block_store_tb.sv]
// Self-checking testbench for the sparse extent block store, with its own predictor of the disk.
module sparse_extent_block_store_tb;
    import sebs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Geometry of the disk under test. The same values are passed to the block's parameters.
    localparam int SECTORS          = 4096;
    localparam int WORDS_PER_SECTOR = 128;
    localparam int EXTENT_MAX       = 8;
    localparam int POOL_SLOTS       = 8;
    localparam int SLOT_WORDS       = EXTENT_MAX * WORDS_PER_SECTOR;
    localparam int STORE_WORDS      = POOL_SLOTS * SLOT_WORDS;

    // The fourth action code is not defined; the block must answer it with an empty reply.
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    localparam int TOTAL_ITEMS = 850;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [LBA_W-1:0]  lba;
        logic [WORD_W-1:0] word;
        logic [DATA_W-1:0] wdata;
        logic [FILL_W-1:0] fill;
    } t_disk_req;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              status;
    } t_disk_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [ACT_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    // Requests waiting to be offered, and replies the predictor has worked out but the block
    // has not yet delivered.
    t_disk_req   request_queue [$];
    t_disk_reply awaited_replies [$];
    t_disk_req   on_bus;
    t_disk_reply oldest;

    int unsigned items_queued = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned errors = 0;

    // Idling state of both sides. A quiet count gives a stretch with no gaps at all.
    int unsigned tx_gap = 0;
    int unsigned tx_quiet = 0;
    int unsigned rx_stall = 0;
    int unsigned rx_quiet = 0;
    logic        rx_hold = 1'b0;

    // Predictor state: the extent map, the slot pool, the fill byte and the extent size.
    bit                 mapped [SECTORS];
    bit [2:0]           slot_of [SECTORS];
    bit [DATA_W-1:0]    disk_words [STORE_WORDS];
    int unsigned        slots_taken = 0;
    bit [FILL_W-1:0]    fill_byte = '0;
    bit [CFG_W-1:0]     extent_size = CFG_RESET;

    // What the run has touched, for the closing summary.
    int unsigned n_hit_reads = 0;
    int unsigned n_blank_reads = 0;
    int unsigned n_writes = 0;
    int unsigned n_allocs = 0;
    int unsigned n_rejects = 0;
    int unsigned n_formats = 0;
    int unsigned n_spare = 0;
    int unsigned n_sizes = 0;

    sparse_extent_block_store #(
        .SECTOR_COUNT       (SECTORS),
        .SECTOR_WORDS       (WORDS_PER_SECTOR),
        .MAX_EXTENT_SECTORS (EXTENT_MAX),
        .POOL_EXTENTS       (POOL_SLOTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one request to the predicted disk and returns the reply it should produce.
    // A zero extent size behaves as one sector, and sizes beyond the slot are clamped to it.
    function automatic t_disk_reply disk_access(t_disk_req rq);
        t_disk_reply rs;
        int unsigned es;
        int unsigned ext;
        int unsigned word_pos;
        rs = '0;
        case (rq.action)
            ACT_FORMAT: begin
                for (int e = 0; e < SECTORS; e++) mapped[e] = 1'b0;
                slots_taken = 0;
                fill_byte = rq.fill;
                n_formats++;
            end
            ACT_READ, ACT_WRITE: begin
                es = (extent_size == 0) ? 1 : extent_size;
                if (es > EXTENT_MAX) es = EXTENT_MAX;
                ext = rq.lba / es;
                word_pos = (rq.lba % es) * WORDS_PER_SECTOR + rq.word;
                if (rq.action == ACT_READ) begin
                    if (mapped[ext]) begin
                        rs.rdata = disk_words[slot_of[ext] * SLOT_WORDS + word_pos];
                        n_hit_reads++;
                    end else begin
                        rs.rdata = {4{fill_byte}};
                        n_blank_reads++;
                    end
                end else begin
                    if (!mapped[ext]) begin
                        if (slots_taken >= POOL_SLOTS) begin
                            rs.status = 1'b1;
                            n_rejects++;
                        end else begin
                            // A freshly taken slot reads as zero everywhere.
                            mapped[ext] = 1'b1;
                            slot_of[ext] = 3'(slots_taken);
                            for (int w = 0; w < SLOT_WORDS; w++)
                                disk_words[slots_taken * SLOT_WORDS + w] = '0;
                            slots_taken++;
                            n_allocs++;
                        end
                    end
                    if (!rs.status) begin
                        disk_words[slot_of[ext] * SLOT_WORDS + word_pos] = rq.wdata;
                        n_writes++;
                    end
                end
            end
            default: n_spare++;
        endcase
        return rs;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run of back-to-back cycles.
    function automatic int unsigned pick_gap(inout int unsigned quiet);
        int unsigned r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sender: offers the next queued request after a random gap and holds it until the
    // transfer. The prediction is made at the moment the block takes the request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_replies.push_back(disk_access(on_bus));
                items_accepted++;
                tx_gap = pick_gap(tx_quiet);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    on_bus = request_queue.pop_front();
                    s_tdata  <= S_TDATA_W'({on_bus.fill, on_bus.wdata, on_bus.word, on_bus.lba});
                    s_tuser  <= on_bus.action;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every reply against the oldest prediction and stalls at random.
    // The padding above the status bit must read as zero as well.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_replies.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("error: reply %h arrived with nothing outstanding", m_tdata);
                end else begin
                    oldest = awaited_replies.pop_front();
                    results_seen++;
                    if (m_tdata[DATA_W-1:0] !== oldest.rdata || m_tdata[DATA_W] !== oldest.status
                            || m_tdata[M_TDATA_W-1:DATA_W+1] !== '0) begin
                        errors++;
                        if (errors <= 10)
                            $display({"error: reply %0d read_data exp %h got %h, ",
                                      "status exp %0d got %0d, pad %h"},
                                     results_seen, oldest.rdata, m_tdata[DATA_W-1:0],
                                     oldest.status, m_tdata[DATA_W], m_tdata[M_TDATA_W-1:DATA_W+1]);
                    end
                end
                rx_stall = pick_gap(rx_quiet);
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long hold-off on the reply side while requests are still queued, so that the output
    // register and the request stage both fill and the block has to drop s_tready.
    initial begin
        while (!(items_accepted > 300 && request_queue.size() > 20)) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (500) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic queue_request(input logic [ACT_W-1:0] action, input logic [LBA_W-1:0] lba,
                                 input logic [WORD_W-1:0] word, input logic [DATA_W-1:0] wdata,
                                 input logic [FILL_W-1:0] fill);
        request_queue.push_back('{action, lba, word, wdata, fill});
        items_queued++;
    endtask

    task automatic wait_replies();
        while (results_seen != items_queued) @(posedge i_clk);
    endtask

    // Only called once every reply is in, so the block is idle when the size changes.
    task automatic set_extent_size(input logic [CFG_W-1:0] size);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        extent_size = size;
        n_sizes++;
    endtask

    // One burst of disk traffic around a small set of hot addresses, so that reads find the
    // words written before them. Stray writes anywhere drain the pool and provoke rejects;
    // reads near a hot sector land on zeroed words of the same slot or on unmapped extents.
    task automatic add_episode(input int unsigned n_items, input bit format_first);
        logic [LBA_W-1:0]  hot_lba [8];
        logic [WORD_W-1:0] hot_word [8];
        int unsigned       pick;
        int unsigned       k;
        for (int i = 0; i < 8; i++) begin
            hot_lba[i]  = LBA_W'($urandom_range(0, SECTORS - 1));
            hot_word[i] = WORD_W'($urandom_range(0, WORDS_PER_SECTOR - 1));
        end
        if (format_first)
            queue_request(ACT_FORMAT, LBA_W'($urandom), WORD_W'($urandom), $urandom,
                          FILL_W'($urandom));
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            k = $urandom_range(0, 7);
            if (pick < 42) begin
                queue_request(ACT_WRITE, hot_lba[k], hot_word[k], $urandom, FILL_W'($urandom));
            end else if (pick < 70) begin
                queue_request(ACT_READ, hot_lba[k], hot_word[k], $urandom, FILL_W'($urandom));
            end else if (pick < 84) begin
                queue_request(ACT_READ, hot_lba[k] ^ LBA_W'($urandom_range(0, 7)),
                              WORD_W'($urandom), $urandom, FILL_W'($urandom));
            end else if (pick < 94) begin
                queue_request(pick[0] ? ACT_WRITE : ACT_READ, LBA_W'($urandom),
                              WORD_W'($urandom), $urandom, FILL_W'($urandom));
            end else if (pick < 98) begin
                queue_request(ACT_SPARE, LBA_W'($urandom), WORD_W'($urandom), $urandom,
                              FILL_W'($urandom));
            end else begin
                queue_request(ACT_FORMAT, LBA_W'($urandom), WORD_W'($urandom), $urandom,
                              FILL_W'($urandom));
            end
        end
    endtask

    // Stimulus and end of run.
    initial begin
        logic [CFG_W-1:0] extreme_sizes [4];
        logic [CFG_W-1:0] size_sel;
        int unsigned      phase;
        int unsigned      phase_start;
        bit               first;
        extreme_sizes = '{4'd1, 4'd0, 4'd15, 4'd8};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset extent size of eight sectors.
        queue_request(ACT_READ,   12'd0,    7'd0,   32'h0,        8'h00);
        queue_request(ACT_FORMAT, 12'd0,    7'd0,   32'h0,        8'hA5);
        queue_request(ACT_READ,   12'd4095, 7'd127, 32'h0,        8'h00);
        queue_request(ACT_WRITE,  12'd4095, 7'd127, 32'hFFFF_FFFF, 8'hFF);
        queue_request(ACT_READ,   12'd4095, 7'd127, 32'h0,        8'h00);
        queue_request(ACT_READ,   12'd4088, 7'd0,   32'h0,        8'h00);
        queue_request(ACT_READ,   12'd4087, 7'd127, 32'h0,        8'h00);
        queue_request(ACT_WRITE,  12'd0,    7'd0,   32'h0,        8'h00);
        queue_request(ACT_SPARE,  12'd4095, 7'd127, 32'hFFFF_FFFF, 8'hFF);
        // Fill the remaining six slots, then overflow the pool.
        for (int i = 1; i <= 6; i++)
            queue_request(ACT_WRITE, LBA_W'(8 * i), WORD_W'(i), 32'hC0DE_0000 + i, 8'h00);
        queue_request(ACT_WRITE,  12'd56,   7'd3,   32'hDEAD_BEEF, 8'h00);
        queue_request(ACT_READ,   12'd56,   7'd3,   32'h0,        8'h00);
        // A write into an extent that already owns a slot still goes through when full.
        queue_request(ACT_WRITE,  12'd1,    7'd5,   32'h1234_5678, 8'h00);
        queue_request(ACT_READ,   12'd1,    7'd5,   32'h0,        8'h00);
        queue_request(ACT_FORMAT, 12'd4095, 7'd127, 32'hFFFF_FFFF, 8'h5A);
        queue_request(ACT_READ,   12'd0,    7'd0,   32'h0,        8'h00);
        wait_replies();

        // Random part in phases, each at its own extent size; the extremes come first.
        // The first episode of a phase sometimes keeps the map, so that extents laid out
        // under the old size are read back under the new one.
        phase = 0;
        while (items_queued < TOTAL_ITEMS) begin
            size_sel = (phase < 4) ? extreme_sizes[phase] : CFG_W'($urandom_range(0, 15));
            set_extent_size(size_sel);
            phase_start = items_queued;
            first = 1'b1;
            while (items_queued - phase_start < PHASE_ITEMS) begin
                if (first)
                    add_episode($urandom_range(15, 40), phase != 0 && $urandom_range(0, 2) != 0);
                else
                    add_episode($urandom_range(15, 40), $urandom_range(0, 9) < 8);
                first = 1'b0;
            end
            wait_replies();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        errors += awaited_replies.size();
        $display({"covered %0d requests over %0d extent sizes: %0d formats, ",
                  "%0d slot allocations, %0d rejected writes"},
                 items_accepted, n_sizes, n_formats, n_allocs, n_rejects);
        $display({"reads of mapped words %0d, of unmapped extents %0d, ",
                  "stored words %0d, undefined actions %0d"},
                 n_hit_reads, n_blank_reads, n_writes, n_spare);
        if (errors == 0) begin
            $display("sparse_extent_block_store regression: pass");
        end else begin
            $display("sparse_extent_block_store regression: fail");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run, formats and slot clears included.
    initial begin
        #60_000_000;
        $display("sparse_extent_block_store regression: fail");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sebs_pkg.sv
hw/rtl/sparse_extent_block_store.sv
sim/sparse_extent_block_store_tb.sv
